FILE: design/lea_pkg.sv
package lea_pkg;

	localparam int MAX_ROUNDS = 32;
	localparam int RND_W      = $clog2(MAX_ROUNDS);
	localparam int NUM_KEYW   = 8;
	localparam int NUM_RKW    = 6;
	localparam int PART_W     = 64;

	typedef logic [31:0]              word_t;
	typedef logic [3:0][31:0]         blk_t;
	typedef logic [NUM_RKW-1:0][31:0] rk_t;
	typedef logic [RND_W-1:0]         rnd_t;
	typedef logic [4:0]               rot_t;
	typedef logic [2:0]               kidx_t;

	typedef enum logic [1:0] {
		MODE_128 = 2'd0,
		MODE_192 = 2'd1,
		MODE_256 = 2'd2,
		MODE_RSV = 2'd3
	} key_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_DONE
	} state_t;

	// control from the sequencer to the key schedule
	typedef struct packed {
		logic      load;
		logic      step;
		key_mode_t mode;
	} ks_ctrl_t;

	localparam word_t DELTA [NUM_KEYW] = '{
		32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
		32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
	};

	localparam rot_t KS_ROT [NUM_RKW] = '{5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17};

	// last delta index before wrap, per key length
	localparam kidx_t DSEL_LAST_128 = 3'd3;
	localparam kidx_t DSEL_LAST_192 = 3'd5;
	localparam kidx_t DSEL_LAST_256 = 3'd7;

	// last round index, per key length
	localparam rnd_t LAST_128 = rnd_t'(24 - 1);
	localparam rnd_t LAST_192 = rnd_t'(28 - 1);
	localparam rnd_t LAST_256 = rnd_t'(MAX_ROUNDS - 1);

	// register indexes on the configuration port
	localparam logic [2:0] REG_KEY_MODE  = 3'd0;
	localparam logic [2:0] REG_KEY_PART0 = 3'd1;
	localparam logic [2:0] REG_KEY_PART1 = 3'd2;
	localparam logic [2:0] REG_KEY_PART2 = 3'd3;
	localparam logic [2:0] REG_KEY_PART3 = 3'd4;

	function automatic word_t rotl(word_t x, rot_t r);
		logic [63:0] w;
		w = {x, x} << r;
		return w[63:32];
	endfunction

	function automatic blk_t enc_round(blk_t x, rk_t k);
		blk_t n;
		n[0] = rotl((x[0] ^ k[0]) + (x[1] ^ k[1]), 5'd9);
		n[1] = rotl((x[1] ^ k[2]) + (x[2] ^ k[3]), 5'd27);
		n[2] = rotl((x[2] ^ k[4]) + (x[3] ^ k[5]), 5'd29);
		n[3] = x[0];
		return n;
	endfunction

	function automatic blk_t dec_round(blk_t x, rk_t k);
		blk_t n;
		n[0] = x[3];
		n[1] = (rotl(x[0], 5'd23) - (n[0] ^ k[0])) ^ k[1];
		n[2] = (rotl(x[1], 5'd5)  - (n[1] ^ k[2])) ^ k[3];
		n[3] = (rotl(x[2], 5'd3)  - (n[2] ^ k[4])) ^ k[5];
		return n;
	endfunction

endpackage

FILE: design/lea_key_sched.sv
module lea_key_sched (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lea_pkg::ks_ctrl_t                     ctrl,
	input  lea_pkg::word_t [lea_pkg::NUM_KEYW-1:0] key_words,
	output lea_pkg::rk_t                          rk
);

	lea_pkg::word_t t_q [lea_pkg::NUM_KEYW];
	lea_pkg::rnd_t  i_q;
	lea_pkg::kidx_t dsel_q;
	lea_pkg::kidx_t base_q;

	lea_pkg::word_t val [lea_pkg::NUM_RKW];
	lea_pkg::kidx_t idx [lea_pkg::NUM_RKW];
	lea_pkg::word_t t_next [lea_pkg::NUM_KEYW];
	lea_pkg::kidx_t dsel_last;
	lea_pkg::word_t d;

	// one key-schedule round: update the key words that this round touches
	always_comb begin
		d = lea_pkg::DELTA[dsel_q];
		for (int j = 0; j < lea_pkg::NUM_KEYW; j++) begin
			t_next[j] = t_q[j];
		end
		for (int j = 0; j < lea_pkg::NUM_RKW; j++) begin
			idx[j] = (ctrl.mode == lea_pkg::MODE_128 || ctrl.mode == lea_pkg::MODE_192) ?
				lea_pkg::kidx_t'(j) : lea_pkg::kidx_t'(base_q + lea_pkg::kidx_t'(j));
			val[j] = lea_pkg::rotl(t_q[idx[j]] + lea_pkg::rotl(d, i_q + lea_pkg::rot_t'(j)),
				lea_pkg::KS_ROT[j]);
			if (ctrl.mode != lea_pkg::MODE_128 || j < 4) begin
				t_next[idx[j]] = val[j];
			end
		end
		if (ctrl.mode == lea_pkg::MODE_128) begin
			rk = {val[1], val[3], val[1], val[2], val[1], val[0]};
		end else begin
			rk = {val[5], val[4], val[3], val[2], val[1], val[0]};
		end
	end

	// pick the delta wrap point
	always_comb begin
		case (ctrl.mode)
			lea_pkg::MODE_128: dsel_last = lea_pkg::DSEL_LAST_128;
			lea_pkg::MODE_192: dsel_last = lea_pkg::DSEL_LAST_192;
			default:           dsel_last = lea_pkg::DSEL_LAST_256;
		endcase
	end

	// advance the round counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			dsel_q <= '0;
			base_q <= '0;
		end else if (ctrl.load) begin
			i_q    <= '0;
			dsel_q <= '0;
			base_q <= '0;
		end else if (ctrl.step) begin
			i_q    <= i_q + 1'b1;
			dsel_q <= (dsel_q == dsel_last) ? '0 : dsel_q + 1'b1;
			base_q <= base_q + 3'd6;
		end
	end

	// hold the working key words
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int j = 0; j < lea_pkg::NUM_KEYW; j++) begin
				t_q[j] <= key_words[j];
			end
		end else if (ctrl.step) begin
			for (int j = 0; j < lea_pkg::NUM_KEYW; j++) begin
				t_q[j] <= t_next[j];
			end
		end
	end

endmodule

FILE: design/lea_block_cipher.sv
// Flow: N = 24, 28 or 32 rounds for a 128, 192 or 256 bit key. After an accepted input word
// the key schedule writes N round keys into the round-key memory, a read setup state follows,
// the block runs N rounds through the shared round unit, then goes to the output register.
// A new block is taken only once the last one is through; s_tready is low while busy.
// Reset (arst_n low) clears the sequencer and output valid, sets key_mode to 1
// (192 bit) and the key registers to zero.
module lea_block_cipher (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // block_word0, block_word1, block_word2, block_word3
	input  logic [0:0]   s_tuser,  // cmd
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // out_word0, out_word1, out_word2, out_word3
);

	logic [1:0]             key_mode_q;
	logic [lea_pkg::PART_W-1:0] key_part_q [4];

	lea_pkg::state_t    state_q, state_d;
	lea_pkg::rnd_t      cnt_q;
	lea_pkg::rnd_t      last_rnd;
	lea_pkg::rnd_t      rd_addr;
	lea_pkg::key_mode_t mode_q;
	logic               dec_q;
	lea_pkg::blk_t      x_q;
	lea_pkg::blk_t      out_q;
	logic               out_valid_q;

	lea_pkg::ks_ctrl_t  ks_ctrl;
	lea_pkg::rk_t       rk;
	lea_pkg::rk_t       rk_rd_q;
	lea_pkg::rk_t       rk_mem [lea_pkg::MAX_ROUNDS];
	lea_pkg::word_t [lea_pkg::NUM_KEYW-1:0] key_words;

	logic accept;
	logic mem_we;
	logic out_load;
	logic cfg_wr;
	lea_pkg::key_mode_t mode_in;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q <= 2'd1;
			for (int j = 0; j < 4; j++) begin
				key_part_q[j] <= '0;
			end
		end else if (cfg_wr) begin
			case (paddr[5:3])
				lea_pkg::REG_KEY_MODE:  key_mode_q    <= pwdata[1:0];
				lea_pkg::REG_KEY_PART0: key_part_q[0] <= pwdata;
				lea_pkg::REG_KEY_PART1: key_part_q[1] <= pwdata;
				lea_pkg::REG_KEY_PART2: key_part_q[2] <= pwdata;
				lea_pkg::REG_KEY_PART3: key_part_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[5:3])
			lea_pkg::REG_KEY_MODE:  prdata = {62'd0, key_mode_q};
			lea_pkg::REG_KEY_PART0: prdata = key_part_q[0];
			lea_pkg::REG_KEY_PART1: prdata = key_part_q[1];
			lea_pkg::REG_KEY_PART2: prdata = key_part_q[2];
			lea_pkg::REG_KEY_PART3: prdata = key_part_q[3];
			default:                prdata = '0;
		endcase
	end

	// split key parts into 32-bit key words
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			key_words[2*j]   = key_part_q[j][31:0];
			key_words[2*j+1] = key_part_q[j][63:32];
		end
	end

	// treat the reserved key mode as 256 bit
	assign mode_in = (key_mode_q == lea_pkg::MODE_RSV) ? lea_pkg::MODE_256 :
		lea_pkg::key_mode_t'(key_mode_q);

	always_comb begin
		case (mode_q)
			lea_pkg::MODE_128: last_rnd = lea_pkg::LAST_128;
			lea_pkg::MODE_192: last_rnd = lea_pkg::LAST_192;
			default:           last_rnd = lea_pkg::LAST_256;
		endcase
	end

	lea_key_sched u_ks (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ks_ctrl),
		.key_words (key_words),
		.rk        (rk)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lea_pkg::ST_IDLE:   if (accept) state_d = lea_pkg::ST_EXPAND;
			lea_pkg::ST_EXPAND: if (cnt_q == last_rnd) state_d = lea_pkg::ST_LOAD;
			lea_pkg::ST_LOAD:   state_d = lea_pkg::ST_ROUND;
			lea_pkg::ST_ROUND:  if (cnt_q == last_rnd) state_d = lea_pkg::ST_DONE;
			lea_pkg::ST_DONE:   if (!out_valid_q || m_tready) state_d = lea_pkg::ST_IDLE;
			default:            state_d = lea_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready     = 1'b0;
		ks_ctrl.load = 1'b0;
		ks_ctrl.step = 1'b0;
		ks_ctrl.mode = mode_q;
		mem_we       = 1'b0;
		out_load     = 1'b0;
		rd_addr      = dec_q ? last_rnd - cnt_q - 1'b1 : cnt_q + 1'b1;
		case (state_q)
			lea_pkg::ST_IDLE: begin
				s_tready     = 1'b1;
				ks_ctrl.load = 1'b1;
			end
			lea_pkg::ST_EXPAND: begin
				ks_ctrl.step = 1'b1;
				mem_we       = 1'b1;
			end
			lea_pkg::ST_LOAD: begin
				rd_addr = dec_q ? last_rnd : '0;
			end
			lea_pkg::ST_DONE: begin
				out_load = !out_valid_q || m_tready;
			end
			default: ;
		endcase
	end

	// sequencer state and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lea_pkg::ST_IDLE;
			cnt_q   <= '0;
			mode_q  <= lea_pkg::MODE_192;
			dec_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q <= mode_in;
				dec_q  <= s_tuser[0];
			end
			if ((state_q == lea_pkg::ST_EXPAND || state_q == lea_pkg::ST_ROUND) &&
				cnt_q != last_rnd) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// round-key memory: write during expansion, registered read during rounds
	always_ff @(posedge clk) begin
		if (mem_we) begin
			rk_mem[cnt_q] <= rk;
		end
		rk_rd_q <= rk_mem[rd_addr];
	end

	// block state: load on accept, one round per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= s_tdata;
		end else if (state_q == lea_pkg::ST_ROUND) begin
			x_q <= dec_q ? lea_pkg::dec_round(x_q, rk_rd_q) : lea_pkg::enc_round(x_q, rk_rd_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= x_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

FILE: design/lea_checker.sv
module lea_checker (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pready,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// drop ready after taking a word, while the block is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input taken while busy");

	// a new result appears only at the end of a busy period
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without finished work");

	// configuration access never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("configuration wait state");

endmodule

bind lea_block_cipher lea_checker u_lea_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pready   (pready),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

FILE: tb/tb_lea_block_cipher.sv
module tb_lea_block_cipher;
	timeunit 1ns;
	timeprecision 1ps;

	import lea_pkg::*;

	// key schedule constants, kept apart from the design's own copies
	localparam word_t KEY_DELTA [8] = '{
		32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
		32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
	};
	localparam int KEY_SHIFT [6] = '{1, 3, 6, 11, 13, 17};
	localparam int MAX_PRINTED = 40;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [5:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;  // block_word0, block_word1, block_word2, block_word3
	logic [0:0]   s_tuser;  // cmd
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;  // out_word0, out_word1, out_word2, out_word3

	// mirror of the register file
	key_mode_t   cfg_mode;
	logic [63:0] cfg_key [4];

	// round keys of the current block
	word_t round_key [MAX_ROUNDS][6];

	// blocks still owed by the design, oldest first
	blk_t expected_blocks [$];

	int    err_count;
	bit    tx_gaps_on;
	bit    rx_stall_en;
	int    rx_hold_len;

	lea_block_cipher u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// cipher prediction
	// ------------------------------------------------------------------

	function automatic word_t rol(word_t x, int r);
		r = r & 31;
		if (r == 0)
			return x;
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic word_t ror(word_t x, int r);
		return rol(x, (32 - (r & 31)) & 31);
	endfunction

	// expand the mirrored key into round_key, return the round count
	function automatic int build_schedule();
		word_t t [8];
		word_t d;
		int    nr;
		int    i;
		int    j;
		int    idx;
		for (i = 0; i < 4; i++) begin
			t[2*i]   = cfg_key[i][31:0];
			t[2*i+1] = cfg_key[i][63:32];
		end
		case (cfg_mode)
			MODE_128: nr = 24;
			MODE_192: nr = 28;
			default:  nr = 32;
		endcase
		if (nr > MAX_ROUNDS)
			nr = MAX_ROUNDS;
		for (i = 0; i < nr; i++) begin
			case (cfg_mode)
				MODE_128: begin
					d = KEY_DELTA[i % 4];
					for (j = 0; j < 4; j++)
						t[j] = rol(t[j] + rol(d, i + j), KEY_SHIFT[j]);
					round_key[i][0] = t[0];
					round_key[i][1] = t[1];
					round_key[i][2] = t[2];
					round_key[i][3] = t[1];
					round_key[i][4] = t[3];
					round_key[i][5] = t[1];
				end
				MODE_192: begin
					d = KEY_DELTA[i % 6];
					for (j = 0; j < 6; j++) begin
						t[j] = rol(t[j] + rol(d, i + j), KEY_SHIFT[j]);
						round_key[i][j] = t[j];
					end
				end
				// the spare mode value behaves as a 256 bit key
				default: begin
					d = KEY_DELTA[i % 8];
					for (j = 0; j < 6; j++) begin
						idx = (6 * i + j) % 8;
						t[idx] = rol(t[idx] + rol(d, i + j), KEY_SHIFT[j]);
						round_key[i][j] = t[idx];
					end
				end
			endcase
		end
		return nr;
	endfunction

	function automatic blk_t lea_cipher(logic dec, blk_t in_blk);
		blk_t  x;
		word_t head;
		word_t a;
		word_t b;
		word_t c;
		int    nr;
		int    r;
		int    k;
		nr = build_schedule();
		x = in_blk;
		for (r = 0; r < nr; r++) begin
			if (!dec) begin
				k = r;
				head = x[0];
				x[0] = rol((x[0] ^ round_key[k][0]) + (x[1] ^ round_key[k][1]), 9);
				x[1] = ror((x[1] ^ round_key[k][2]) + (x[2] ^ round_key[k][3]), 5);
				x[2] = ror((x[2] ^ round_key[k][4]) + (x[3] ^ round_key[k][5]), 3);
				x[3] = head;
			end else begin
				// inverse round, round keys taken from the end
				k = nr - 1 - r;
				a = x[0];
				b = x[1];
				c = x[2];
				x[0] = x[3];
				x[1] = (ror(a, 9) - (x[0] ^ round_key[k][0])) ^ round_key[k][1];
				x[2] = (rol(b, 5) - (x[1] ^ round_key[k][2])) ^ round_key[k][3];
				x[3] = (rol(c, 3) - (x[2] ^ round_key[k][4])) ^ round_key[k][5];
			end
		end
		return x;
	endfunction

	// ------------------------------------------------------------------
	// shared helpers
	// ------------------------------------------------------------------

	// mostly short idles, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	function automatic word_t pick_word();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic blk_t pick_block();
		blk_t b;
		int   w;
		for (w = 0; w < 4; w++)
			b[w] = pick_word();
		return b;
	endfunction

	task automatic report_mismatch(string msg);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// write one register; call at a rising edge, returns at a rising edge
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_KEY_MODE:  cfg_mode   = key_mode_t'(val[1:0]);
			REG_KEY_PART0: cfg_key[0] = val;
			REG_KEY_PART1: cfg_key[1] = val;
			REG_KEY_PART2: cfg_key[2] = val;
			REG_KEY_PART3: cfg_key[3] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_key(key_mode_t mode, logic [63:0] p0, logic [63:0] p1,
			logic [63:0] p2, logic [63:0] p3);
		write_reg(REG_KEY_MODE, {62'd0, mode});
		write_reg(REG_KEY_PART0, p0);
		write_reg(REG_KEY_PART1, p1);
		write_reg(REG_KEY_PART2, p2);
		write_reg(REG_KEY_PART3, p3);
	endtask

	// offer one word until taken, then idle a while if gaps are on
	task automatic send_block(logic dec, blk_t blk);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= blk;
		s_tuser  <= dec;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		expected_blocks.push_back(lea_cipher(dec, blk));
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// hold until every expected block is out, then let the design settle
	task automatic wait_results();
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset configuration: 192 bit key of zeros
	task automatic test_reset_config();
		send_block(1'b0, '0);
		send_block(1'b1, '0);
		send_block(1'b0, '1);
		send_block(1'b1, '1);
		stop_input();
		wait_results();
	endtask

	// each key length, key extremes, ignored key words, spare mode value
	task automatic test_key_modes();
		load_key(MODE_128, '1, '1, {2{32'hdeadbeef}}, {$urandom, $urandom});
		send_block(1'b0, '0);
		send_block(1'b0, '1);
		send_block(1'b1, '1);
		send_block(1'b1, {4{32'h5555aaaa}});
		stop_input();
		wait_results();

		load_key(MODE_256, '1, '1, '1, '1);
		send_block(1'b0, '0);
		send_block(1'b1, '1);
		stop_input();
		wait_results();

		load_key(MODE_RSV, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		send_block(1'b0, pick_block());
		send_block(1'b1, pick_block());
		stop_input();
		wait_results();

		load_key(MODE_192, '0, {$urandom, $urandom}, '1, {$urandom, $urandom});
		send_block(1'b0, {4{32'haaaa5555}});
		send_block(1'b1, pick_block());
		stop_input();
		wait_results();
	endtask

	// stall the output long enough that the input backs up
	task automatic test_backpressure();
		int i;
		tx_gaps_on  = 1'b0;
		rx_hold_len = 1500;
		for (i = 0; i < 6; i++)
			send_block(1'($urandom_range(0, 1)), pick_block());
		stop_input();
		wait_results();
		tx_gaps_on = 1'b1;
	endtask

	// drain completely between short bursts
	task automatic test_drain_pause();
		int i;
		int j;
		for (i = 0; i < 4; i++) begin
			for (j = 0; j < 3; j++)
				send_block(1'($urandom_range(0, 1)), pick_block());
			stop_input();
			wait_results();
		end
	endtask

	// random keys and blocks over many configurations
	task automatic test_random_traffic();
		logic [63:0] part [4];
		key_mode_t   mode;
		int          phase;
		int          i;
		int          r;
		for (phase = 0; phase < 18; phase++) begin
			mode = key_mode_t'(2'($urandom_range(0, 3)));
			for (i = 0; i < 4; i++) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					part[i] = '0;
				else if (r == 1)
					part[i] = '1;
				else
					part[i] = {$urandom, $urandom};
			end
			load_key(mode, part[0], part[1], part[2], part[3]);
			// alternate idle patterns, one phase in four runs flat out
			tx_gaps_on  = (phase % 4) != 1 && (phase % 4) != 3;
			rx_stall_en = (phase % 4) != 2 && (phase % 4) != 3;
			for (i = 0; i < 90; i++)
				send_block(1'($urandom_range(0, 1)), pick_block());
			stop_input();
			wait_results();
		end
		tx_gaps_on  = 1'b1;
		rx_stall_en = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// output ready driver
	// ------------------------------------------------------------------
	initial begin : ready_driver
		int n;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_len != 0) begin
				n = rx_hold_len;
				rx_hold_len = 0;
			end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
				n = pick_gap();
			end else begin
				n = 0;
			end
			if (n != 0) begin
				m_tready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// result checker: sample at the falling edge before the accepting edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		blk_t got;
		blk_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_blocks.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
			end else begin
				want = expected_blocks.pop_front();
				for (int w = 0; w < 4; w++) begin
					if (got[w] !== want[w])
						report_mismatch($sformatf("out_word%0d got %h want %h",
							w, got[w], want[w]));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	initial begin
		#(30_000_000);
		$display("[lea_block_cipher] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		err_count   = 0;
		tx_gaps_on  = 1'b1;
		rx_stall_en = 1'b1;
		rx_hold_len = 0;
		cfg_mode    = MODE_192;
		for (int i = 0; i < 4; i++)
			cfg_key[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_key_modes();
		test_backpressure();
		test_drain_pause();
		test_random_traffic();

		wait_results();
		repeat (80) @(posedge clk);
		if (err_count == 0)
			$display("[lea_block_cipher] OK");
		else
			$display("[lea_block_cipher] ERROR");
		$finish;
	end

endmodule

FILE: files.f
design/lea_pkg.sv
design/lea_key_sched.sv
design/lea_block_cipher.sv
design/lea_checker.sv
tb/tb_lea_block_cipher.sv
